// ----- hw/rtl/fsep_pkg.sv -----
// shared constants, command codes and types of the frame signal extract and pack block
`default_nettype none

package fsep_pkg;

  localparam int FRAME_BYTES = 64;
  localparam int NUM_BANKS   = 16;
  localparam int BANK_ROWS   = FRAME_BYTES / NUM_BANKS;
  localparam int ROW_W       = $clog2(BANK_ROWS);
  localparam int BANK_W      = $clog2(NUM_BANKS);
  localparam int ADDR_W      = 6;
  localparam int SPAN_W      = ADDR_W + 1;
  localparam int WIN_BYTES   = 9;
  localparam int WIN_W       = 8 * WIN_BYTES;
  localparam int VAL_W       = 64;
  localparam int LEN_W       = 7;
  localparam int SIZE_W      = 7;
  localparam int SB_W        = 9;
  localparam int SHIFT_W     = $clog2(WIN_W);
  localparam int POS_W       = 8;
  // big-endian field lsb in the 72-bit window is BE_BASE + bit - len
  localparam int BE_BASE     = VAL_W + 1;

  typedef enum logic [1:0] {
    CMD_WRITE_BYTE = 2'd0,
    CMD_READ_BYTE  = 2'd1,
    CMD_EXTRACT    = 2'd2,
    CMD_PACK       = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [ADDR_W-1:0] byte_index;
    logic [7:0]        byte_value;
    logic [SIZE_W-1:0] frame_size;
    logic [SB_W-1:0]   sig_start;
    logic [LEN_W-1:0]  sig_len;
    logic              big_endian;
    logic [VAL_W-1:0]  pack_value;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0] addr;
    logic             we;
    logic [7:0]       wdata;
  } bank_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fsep_bank.sv -----
// one byte bank of the frame buffer: four rows, one address shared by read and write
`default_nettype none

module fsep_bank import fsep_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bank_ctrl_t ctrl_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem_q [BANK_ROWS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < BANK_ROWS; r++) begin
        mem_q[r] <= '0;
      end
    end else if (ctrl_i.we) begin
      mem_q[ctrl_i.addr] <= ctrl_i.wdata;
    end
  end

  assign rdata_o = mem_q[ctrl_i.addr];

endmodule

`default_nettype wire

// ----- hw/rtl/fsep_core.sv -----
// byte window gather, signal extract and read-modify-write pack logic
`default_nettype none

module fsep_core import fsep_pkg::*; (
  input  item_t                          item_i,
  input  logic                           advance_i,
  input  logic [NUM_BANKS-1:0][7:0]      bank_rdata_i,
  output bank_ctrl_t [NUM_BANKS-1:0]     bank_ctrl_o,
  output logic [VAL_W-1:0]               result_o
);

  logic                  byte_op;
  logic                  be;
  logic                  len_ok;
  logic                  le_ok;
  logic                  be_ok;
  logic                  total9;
  logic [ADDR_W-1:0]     first;
  logic [2:0]            bitp;
  logic [SIZE_W-1:0]     size_c;
  logic [VAL_W-1:0]      lmask;
  logic [VAL_W-1:0]      raw;
  logic [VAL_W-1:0]      ext_val;
  logic [POS_W-1:0]      pos;
  logic [SPAN_W-1:0]     lastb;
  logic [SHIFT_W-1:0]    sh_e;
  logic [SHIFT_W-1:0]    sh_p;
  logic [SPAN_W-1:0]     addr [WIN_BYTES];
  logic [7:0]            win [WIN_BYTES];
  logic [WIN_W-1:0]      vec;
  logic [WIN_W-1:0]      dvec;
  logic [WIN_W-1:0]      mvec;
  logic [7:0]            nbyte [NUM_BANKS];
  logic [NUM_BANKS-1:0]  wen;
  logic [7:0]            mb;
  logic [7:0]            db;
  logic [BANK_W-1:0]     jb;
  logic [SPAN_W-1:0]     baddr;

  // decode and span geometry
  always_comb begin
    byte_op = (item_i.cmd == CMD_WRITE_BYTE) || (item_i.cmd == CMD_READ_BYTE);
    be      = item_i.big_endian;
    first   = byte_op ? item_i.byte_index : item_i.sig_start[SB_W-1:3];
    bitp    = item_i.sig_start[2:0];
    size_c  = (item_i.frame_size > SIZE_W'(FRAME_BYTES)) ? SIZE_W'(FRAME_BYTES)
                                                         : item_i.frame_size;
    len_ok  = (item_i.sig_len != '0) && (item_i.sig_len <= LEN_W'(VAL_W));
    lmask   = (item_i.sig_len >= LEN_W'(VAL_W)) ? '1
            : ((VAL_W'(1) << item_i.sig_len) - VAL_W'(1));
    pos     = POS_W'(BE_BASE) + POS_W'(bitp) - POS_W'(item_i.sig_len);
    // a big-endian span of nine bytes drops the first byte out of the window
    total9  = pos < POS_W'(8);
    lastb   = SPAN_W'(first) + SPAN_W'(WIN_BYTES - 1) - SPAN_W'(pos[POS_W-2:3]);
    le_ok   = SPAN_W'(first) < SPAN_W'(size_c);
    be_ok   = lastb < SPAN_W'(size_c);
  end

  // gather window bytes, little-endian bytes at slot j, big-endian at slot 8-j
  always_comb begin
    vec = '0;
    for (int j = 0; j < WIN_BYTES; j++) begin
      addr[j] = SPAN_W'(first) + SPAN_W'(j);
      win[j]  = addr[j][ADDR_W] ? 8'h00 : bank_rdata_i[addr[j][BANK_W-1:0]];
      if (be) begin
        vec[8*(WIN_BYTES-1-j) +: 8] = win[j];
      end else if ((j < WIN_BYTES - 1) && (addr[j] < SPAN_W'(size_c))) begin
        vec[8*j +: 8] = win[j];
      end
    end
  end

  // extract
  always_comb begin
    if (be) begin
      sh_e = total9 ? (SHIFT_W'(pos) + SHIFT_W'(8)) : SHIFT_W'(pos);
    end else begin
      sh_e = SHIFT_W'(bitp);
    end
    ext_val = VAL_W'(vec >> sh_e) & lmask;
  end

  // pack: place value and field mask in the window, merge per byte
  always_comb begin
    raw  = item_i.pack_value & lmask;
    sh_p = be ? SHIFT_W'(pos) : SHIFT_W'(bitp);
    dvec = WIN_W'(raw) << sh_p;
    if (!be || total9) begin
      dvec[WIN_W-1 -: 8] = '0;
    end
    mvec = WIN_W'(lmask) << sh_p;
    for (int k = 0; k < NUM_BANKS; k++) begin
      nbyte[k] = '0;
    end
    wen = '0;
    mb  = '0;
    db  = '0;
    for (int j = 0; j < WIN_BYTES; j++) begin
      if (be) begin
        mb = mvec[8*(WIN_BYTES-1-j) +: 8];
        db = dvec[8*(WIN_BYTES-1-j) +: 8];
      end else begin
        mb = mvec[8*j +: 8];
        db = dvec[8*j +: 8];
      end
      if (item_i.cmd == CMD_WRITE_BYTE) begin
        nbyte[j] = item_i.byte_value;
        wen[j]   = (j == 0);
      end else begin
        nbyte[j] = (win[j] & ~mb) | (db & mb);
        wen[j]   = (item_i.cmd == CMD_PACK) && len_ok && !addr[j][ADDR_W]
                 && (be ? be_ok : (addr[j] < SPAN_W'(size_c)));
      end
    end
  end

  // route window slots to banks
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      jb    = BANK_W'(b) - first[BANK_W-1:0];
      baddr = SPAN_W'(first) + SPAN_W'(jb);
      bank_ctrl_o[b].addr  = baddr[ADDR_W-1:BANK_W];
      bank_ctrl_o[b].we    = advance_i && wen[jb];
      bank_ctrl_o[b].wdata = nbyte[jb];
    end
  end

  always_comb begin
    case (item_i.cmd)
      CMD_READ_BYTE: result_o = VAL_W'(win[0]);
      CMD_EXTRACT:   result_o = (len_ok && (be ? be_ok : le_ok)) ? ext_val : '0;
      default:       result_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/frame_signal_extract_pack.sv -----
// frame signal extract and pack block: top level with input and result registers
//
// Holds one 64-byte bus frame. Each input item carries a command: write a byte,
// read a byte, extract a signal or pack a signal in place. Every item gives
// exactly one result item on result_value_o (the signal or the byte read, zero
// for write and pack).
// Both channels are valid/ready. An accepted item sits in the input register
// while the banked buffer is read, the signal is shifted out or merged in and
// the buffer bytes are written back; the result lands in the output register
// when the item moves on.
// Throughput is one item per cycle while the receiver does not stall, set by the
// read-modify-write of the 16 byte banks; a pack is seen by the item right after it.
// When the receiver stalls, the result is held and the item in the input
// register waits; in_ready_o drops only while both registers are full.
// Reset clears the whole frame buffer to zero and empties both registers.
`default_nettype none

module frame_signal_extract_pack import fsep_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           cmd_i,
  input  logic [ADDR_W-1:0]    byte_index_i,
  input  logic [7:0]           byte_value_i,
  input  logic [SIZE_W-1:0]    frame_size_i,
  input  logic [SB_W-1:0]      start_bit_i,
  input  logic [LEN_W-1:0]     bit_length_i,
  input  logic                 big_endian_i,
  input  logic [VAL_W-1:0]     pack_value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [VAL_W-1:0]     result_value_o
);

  logic                       in_valid_d, in_valid_q;
  item_t                      in_d, in_q;
  logic                       out_valid_d, out_valid_q;
  logic [VAL_W-1:0]           result_d, result_q;
  logic                       advance;
  logic [VAL_W-1:0]           core_result;
  logic [NUM_BANKS-1:0][7:0]  bank_rdata;
  bank_ctrl_t [NUM_BANKS-1:0] bank_ctrl;
  logic [NUM_BANKS-1:0]       bank_we;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_d = '{
      cmd:        cmd_e'(cmd_i),
      byte_index: byte_index_i,
      byte_value: byte_value_i,
      frame_size: frame_size_i,
      sig_start:  start_bit_i,
      sig_len:    bit_length_i,
      big_endian: big_endian_i,
      pack_value: pack_value_i
    };
    in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
    out_valid_d = advance || (out_valid_q && !out_ready_i);
    result_d    = advance ? core_result : result_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_d;
    end
    result_q <= result_d;
  end

  fsep_core u_core (
    .item_i       (in_q),
    .advance_i    (advance),
    .bank_rdata_i (bank_rdata),
    .bank_ctrl_o  (bank_ctrl),
    .result_o     (core_result)
  );

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    fsep_bank u_bank (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (bank_ctrl[b]),
      .rdata_o (bank_rdata[b])
    );
    assign bank_we[b] = bank_ctrl[b].we;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;

  // buffer changes only when the item moves on
  a_no_write_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |-> (bank_we == '0))
    else $error("bank written while item held");

  a_write_byte_one_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_q.cmd == CMD_WRITE_BYTE) |-> $onehot(bank_we))
    else $error("write byte must hit exactly one bank");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not loaded");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && ((in_q.cmd == CMD_WRITE_BYTE) || (in_q.cmd == CMD_PACK))
    |=> (result_q == '0))
    else $error("write or pack gave a nonzero result");

  a_read_byte_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_q.cmd == CMD_READ_BYTE) |=> (result_q[VAL_W-1:8] == '0))
    else $error("read byte result wider than a byte");

endmodule

`default_nettype wire
